@@ rtl/core/tlnt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tetra neighbor table package
// Shared word layouts, operation and status codes, and the command and
// status bundles that pass between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package tlnt_pkg;

   localparam int CORNERS = 4;

   typedef enum logic [2:0] {
      FN_SET_LINK   = 3'd0,
      FN_SET_CORNER = 3'd1,
      FN_DEL_CORNER = 3'd2,
      FN_BUILD      = 3'd3,
      FN_TRIM       = 3'd4,
      FN_CHECK      = 3'd5,
      FN_READ       = 3'd6,
      FN_NOP        = 3'd7
   } func_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_RANGE = 2'd1,
      STAT_UNDER = 2'd2,
      STAT_FULL  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ESEL_SCAN = 2'd0,
      ESEL_WALK = 2'd1,
      ESEL_TRIM = 2'd2,
      ESEL_READ = 2'd3
   } ent_sel_type;

   typedef struct packed {
      logic [2:0] func;
      logic [9:0] tetra;
      logic [9:0] particle;
      logic [5:0] slot;
      logic [9:0] other_tetra;
      logic [1:0] order;
      logic [3:0] search_layer;
      logic [3:0] start_layer;
   } req_word_type;

   typedef struct packed {
      logic [1:0] status;
      logic       found;
      logic [5:0] found_index;
      logic [9:0] neighbor_tetra;
      logic [3:0] neighbor_layer;
      logic [6:0] count_now;
   } rsp_word_type;

   typedef struct packed {
      logic       valid;
      logic [9:0] particle;
   } corner_type;

   typedef struct packed {
      logic       valid;
      logic [1:0] order;
      logic [9:0] tetra;
   } link_type;

   typedef struct packed {
      logic [3:0] layer;
      logic [9:0] tetra;
   } entry_type;

   typedef struct packed {
      logic        load_req;
      logic        clr_step;
      logic        clr_zero;
      logic        vis_clr;
      logic        cnt_rd;
      logic        cnt_load;
      logic        cnt_wb;
      logic        corner_rd;
      logic        corner_src;
      logic        corner_wr;
      logic        corner_set;
      logic        link_rd;
      logic        link_wr;
      logic        ent_rd;
      ent_sel_type ent_sel;
      logic        ent_wr;
      logic        vis_rd;
      logic        vis_set;
      logic        walk_init;
      logic        layer_next;
      logic        layer_begin;
      logic        j_inc;
      logic        src_from_ent;
      logic        k_inc;
      logic        part_load;
      logic        l_clr;
      logic        l_inc;
      logic        f_clr;
      logic        f_inc;
      logic        cnt_inc;
      logic        cnt_dec;
      logic        ccnt_inc;
      logic        ccnt_dec;
      logic        full_set;
      logic        found_set;
      logic        rd_load;
      logic        status_set;
      status_type  status_code;
   } cmd_type;

   typedef struct packed {
      func_type func;
      logic     clr_last;
      logic     vclr_last;
      logic     t_ok;
      logic     p_ok;
      logic     ot_ok;
      logic     link_slot_ok;
      logic     corner_slot_ok;
      logic     read_ok;
      logic     ccnt_zero;
      logic     corner_grow;
      logic     corner_live;
      logic     vis_hit;
      logic     add_here;
      logic     layer_one;
      logic     layer_over;
      logic     k_last;
      logic     l_last;
      logic     link_cand;
      logic     f_end;
      logic     f_match;
      logic     list_full;
      logic     j_end;
      logic     ent_ok;
      logic     cnt_zero;
      logic     trim_hit;
      logic     full;
   } stat_type;

endpackage

@@ rtl/core/tlnt_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tetra neighbor table datapath
// Holds the corner, link, neighbor, count and visited memories, the walk
// counters and the result registers, and acts on the sequencer's commands.
// ----------------------------------------------------------------------------
module tlnt_dpath #(
   parameter int PARTICLES          = 1024,
   parameter int TETRAS             = 1024,
   parameter int LINKS_PER_PARTICLE = 16,
   parameter int NEIGHBOR_MAX       = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  tlnt_pkg::req_word_type req_word,
   input  tlnt_pkg::cmd_type     cmd,
   output tlnt_pkg::stat_type    st,
   output tlnt_pkg::rsp_word_type rsp_word
);
   import tlnt_pkg::*;

   localparam int TW           = $clog2(TETRAS);
   localparam int PW           = $clog2(PARTICLES);
   localparam int LW           = (LINKS_PER_PARTICLE > 1) ? $clog2(LINKS_PER_PARTICLE) : 1;
   localparam int CW           = $clog2(NEIGHBOR_MAX + 1);
   localparam int CORNER_DEPTH = TETRAS * CORNERS;
   localparam int CAW          = TW + 2;
   localparam int LINK_DEPTH   = PARTICLES * LINKS_PER_PARTICLE;
   localparam int LAW          = $clog2(LINK_DEPTH);
   localparam int ENT_DEPTH    = TETRAS * NEIGHBOR_MAX;
   localparam int EAW          = $clog2(ENT_DEPTH);
   localparam int CLR_DEPTH    = (CORNER_DEPTH > LINK_DEPTH) ? CORNER_DEPTH : LINK_DEPTH;
   localparam int CLW          = $clog2(CLR_DEPTH);

   corner_type corner_mem [CORNER_DEPTH];
   link_type   link_mem   [LINK_DEPTH];
   entry_type  ent_mem    [ENT_DEPTH];
   logic       vis_mem    [PARTICLES];
   logic [CW-1:0] ncnt_mem [TETRAS];
   logic [2:0]    ccnt_mem [TETRAS];

   req_word_type  req_ff;
   logic [CW-1:0] cnt_ff, f_ff, j_ff, lo_ff, hi_ff;
   logic [2:0]    ccnt_ff;
   logic [1:0]    k_ff;
   logic [LW-1:0] l_ff;
   logic [4:0]    layer_ff;
   logic [9:0]    src_ff, part_ff;
   logic          full_ff, found_ff;
   logic [1:0]    status_ff;
   logic [5:0]    fidx_ff;
   logic [9:0]    ntet_ff;
   logic [3:0]    nlay_ff;
   logic [CLW-1:0] clr_ff;

   corner_type    corner_q_ff;
   link_type      link_q_ff;
   entry_type     ent_q_ff;
   logic          vis_q_ff;
   logic [CW-1:0] ncnt_q_ff;
   logic [2:0]    ccnt_q_ff;

   logic [TW-1:0]  t_idx;
   logic [CAW-1:0] corner_addr, corner_waddr;
   corner_type     corner_wdata;
   logic           corner_we;
   logic [LAW-1:0] link_rd_addr, link_waddr;
   link_type       link_wdata;
   logic           link_we;
   logic [31:0]    ent_base;
   logic [CW-1:0]  ent_idx;
   logic [EAW-1:0] ent_rd_addr, ent_wr_addr;
   logic [PW-1:0]  vis_waddr;
   logic           vis_we;
   logic           cnt_we;
   logic [TW-1:0]  cnt_waddr;
   logic [9:0]     target;
   logic           t_ok;

   always_comb begin
      t_idx = TW'(req_ff.tetra);
      t_ok  = 32'(req_ff.tetra) < 32'(TETRAS);

      if (cmd.corner_src) begin
         corner_addr = {TW'(src_ff), k_ff};
      end else begin
         corner_addr = {t_idx, req_ff.slot[1:0]};
      end
      corner_we    = (cmd.clr_step && (32'(clr_ff) < 32'(CORNER_DEPTH))) || cmd.corner_wr;
      corner_waddr = cmd.clr_step ? CAW'(clr_ff) : corner_addr;
      corner_wdata = '0;
      if (cmd.corner_wr && cmd.corner_set) begin
         corner_wdata = '{valid: 1'b1, particle: req_ff.particle};
      end

      link_rd_addr = LAW'(32'(part_ff) * 32'(LINKS_PER_PARTICLE) + 32'(l_ff));
      link_we      = (cmd.clr_step && (32'(clr_ff) < 32'(LINK_DEPTH))) || cmd.link_wr;
      if (cmd.clr_step) begin
         link_waddr = LAW'(clr_ff);
         link_wdata = '0;
      end else begin
         link_waddr = LAW'(32'(req_ff.particle) * 32'(LINKS_PER_PARTICLE) +
                           32'(req_ff.slot));
         link_wdata = '{valid: 1'b1, order: req_ff.order, tetra: req_ff.other_tetra};
      end

      case (cmd.ent_sel)
         ESEL_SCAN: ent_idx = f_ff;
         ESEL_WALK: ent_idx = j_ff;
         ESEL_TRIM: ent_idx = cnt_ff - CW'(1);
         ESEL_READ: ent_idx = CW'(req_ff.slot);
         default:   ent_idx = f_ff;
      endcase
      ent_base    = 32'(req_ff.tetra) * 32'(NEIGHBOR_MAX);
      ent_rd_addr = EAW'(ent_base + 32'(ent_idx));
      ent_wr_addr = EAW'(ent_base + 32'(cnt_ff));

      vis_we    = cmd.vis_clr || cmd.vis_set;
      vis_waddr = cmd.vis_clr ? PW'(clr_ff) : PW'(part_ff);

      cnt_we    = (cmd.clr_step && (32'(clr_ff) < 32'(TETRAS))) || cmd.cnt_wb;
      cnt_waddr = cmd.clr_step ? TW'(clr_ff) : t_idx;

      target = (req_ff.func == FN_CHECK) ? req_ff.other_tetra : link_q_ff.tetra;
   end

   // Memories: one write port and one registered read port each.
   always_ff @(posedge clock) begin
      if (corner_we) begin
         corner_mem[corner_waddr] <= corner_wdata;
      end
      if (cmd.corner_rd) begin
         corner_q_ff <= corner_mem[corner_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      if (cmd.link_rd) begin
         link_q_ff <= link_mem[link_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ent_wr) begin
         ent_mem[ent_wr_addr] <= '{layer: layer_ff[3:0], tetra: link_q_ff.tetra};
      end
      if (cmd.ent_rd) begin
         ent_q_ff <= ent_mem[ent_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (vis_we) begin
         vis_mem[vis_waddr] <= cmd.vis_set;
      end
      if (cmd.vis_rd) begin
         vis_q_ff <= vis_mem[PW'(corner_q_ff.particle)];
      end
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         ncnt_mem[cnt_waddr] <= cmd.clr_step ? '0 : cnt_ff;
         ccnt_mem[cnt_waddr] <= cmd.clr_step ? '0 : ccnt_ff;
      end
      if (cmd.cnt_rd) begin
         ncnt_q_ff <= ncnt_mem[t_idx];
         ccnt_q_ff <= ccnt_mem[t_idx];
      end
   end

   // The sweep counter serves the power-up clearing pass and the visited
   // bitmap clear at the start of each build.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clr_zero) begin
         clr_ff <= '0;
      end else if (cmd.clr_step || cmd.vis_clr) begin
         clr_ff <= clr_ff + CLW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff    <= req_word;
         status_ff <= STAT_OK;
         found_ff  <= 1'b0;
         fidx_ff   <= '0;
         ntet_ff   <= '0;
         nlay_ff   <= '0;
         full_ff   <= 1'b0;
      end
      if (cmd.cnt_load) begin
         cnt_ff  <= ncnt_q_ff;
         ccnt_ff <= ccnt_q_ff;
      end
      if (cmd.cnt_inc) begin
         cnt_ff <= cnt_ff + CW'(1);
      end
      if (cmd.cnt_dec) begin
         cnt_ff <= cnt_ff - CW'(1);
      end
      if (cmd.ccnt_inc) begin
         ccnt_ff <= ccnt_ff + 3'd1;
      end
      if (cmd.ccnt_dec) begin
         ccnt_ff <= ccnt_ff - 3'd1;
      end
      if (cmd.walk_init) begin
         src_ff   <= req_ff.tetra;
         k_ff     <= '0;
         layer_ff <= 5'd1;
         lo_ff    <= '0;
         hi_ff    <= '0;
      end
      if (cmd.layer_next) begin
         lo_ff    <= hi_ff;
         layer_ff <= layer_ff + 5'd1;
      end
      if (cmd.layer_begin) begin
         j_ff  <= lo_ff;
         hi_ff <= cnt_ff;
      end
      if (cmd.j_inc) begin
         j_ff <= j_ff + CW'(1);
      end
      if (cmd.src_from_ent) begin
         src_ff <= ent_q_ff.tetra;
         k_ff   <= '0;
      end
      if (cmd.k_inc) begin
         k_ff <= k_ff + 2'd1;
      end
      if (cmd.part_load) begin
         part_ff <= corner_q_ff.particle;
      end
      if (cmd.l_clr) begin
         l_ff <= '0;
      end
      if (cmd.l_inc) begin
         l_ff <= l_ff + LW'(1);
      end
      if (cmd.f_clr) begin
         f_ff <= '0;
      end
      if (cmd.f_inc) begin
         f_ff <= f_ff + CW'(1);
      end
      if (cmd.full_set) begin
         full_ff <= 1'b1;
      end
      if (cmd.found_set) begin
         found_ff <= 1'b1;
         fidx_ff  <= 6'(f_ff);
      end
      if (cmd.rd_load) begin
         ntet_ff <= ent_q_ff.tetra;
         nlay_ff <= ent_q_ff.layer;
      end
      if (cmd.status_set) begin
         status_ff <= cmd.status_code;
      end
   end

   always_comb begin
      st.func           = func_type'(req_ff.func);
      st.clr_last       = 32'(clr_ff) == 32'(CLR_DEPTH - 1);
      st.vclr_last      = 32'(clr_ff) == 32'(PARTICLES - 1);
      st.t_ok           = t_ok;
      st.p_ok           = 32'(req_ff.particle) < 32'(PARTICLES);
      st.ot_ok          = 32'(req_ff.other_tetra) < 32'(TETRAS);
      st.link_slot_ok   = 32'(req_ff.slot) < 32'(LINKS_PER_PARTICLE);
      st.corner_slot_ok = req_ff.slot[5:2] == 4'd0;
      st.read_ok        = 32'(req_ff.slot) < 32'(cnt_ff);
      st.ccnt_zero      = ccnt_ff == 3'd0;
      st.corner_grow    = !corner_q_ff.valid && (ccnt_ff < 3'(CORNERS));
      st.corner_live    = corner_q_ff.valid &&
                          (32'(corner_q_ff.particle) < 32'(PARTICLES));
      st.vis_hit        = vis_q_ff;
      // Layer one adds only when the walk starts there; later layers add
      // from the start layer on.
      st.add_here       = (layer_ff == 5'd1) ? (req_ff.start_layer == 4'd1) :
                          ({1'b0, req_ff.start_layer} <= layer_ff);
      st.layer_one      = layer_ff == 5'd1;
      st.layer_over     = layer_ff > {1'b0, req_ff.search_layer};
      st.k_last         = k_ff == 2'(CORNERS - 1);
      st.l_last         = 32'(l_ff) == 32'(LINKS_PER_PARTICLE - 1);
      st.link_cand      = link_q_ff.valid && (link_q_ff.tetra != req_ff.tetra);
      st.f_end          = f_ff == cnt_ff;
      st.f_match        = ent_q_ff.tetra == target;
      st.list_full      = 32'(cnt_ff) >= 32'(NEIGHBOR_MAX);
      st.j_end          = j_ff == hi_ff;
      st.ent_ok         = 32'(ent_q_ff.tetra) < 32'(TETRAS);
      st.cnt_zero       = cnt_ff == '0;
      st.trim_hit       = ent_q_ff.layer >= req_ff.start_layer;
      st.full           = full_ff;
   end

   always_comb begin
      rsp_word.status         = status_ff;
      rsp_word.found          = found_ff;
      rsp_word.found_index    = fidx_ff;
      rsp_word.neighbor_tetra = ntet_ff;
      rsp_word.neighbor_layer = nlay_ff;
      rsp_word.count_now      = t_ok ? 7'(cnt_ff) : 7'd0;
   end

endmodule

@@ rtl/core/tlnt_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tetra neighbor table sequencer
// Steps each operation through the datapath: count fetch, table updates,
// the layered neighbor walk, list scans, trim and the result strobe.
// ----------------------------------------------------------------------------
module tlnt_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  tlnt_pkg::stat_type st,
   output tlnt_pkg::cmd_type  cmd,
   output logic               busy,
   output logic               rsp_valid
);
   import tlnt_pkg::*;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_CNT, ST_LOAD, ST_OP, ST_SC, ST_WB,
      ST_VCLR, ST_B_CRD, ST_B_CCHK, ST_B_VCHK, ST_K_NEXT, ST_LAYER,
      ST_J_NEXT, ST_J_WAIT, ST_LINK_RD, ST_LINK_CHK, ST_LINK_NEXT,
      ST_F_NEXT, ST_F_WAIT, ST_TRIM, ST_T_WAIT, ST_RD_WAIT
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, rsp_valid_ff, done_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      done_in  = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (st.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               state_in     = ST_CNT;
            end
         end
         ST_CNT: begin
            cmd.cnt_rd = 1'b1;
            state_in   = ST_LOAD;
         end
         ST_LOAD: begin
            cmd.cnt_load = 1'b1;
            state_in     = ST_OP;
         end
         ST_OP: begin
            if (st.func == FN_NOP) begin
               done_in  = 1'b1;
               state_in = ST_IDLE;
            end else if (st.func == FN_SET_LINK) begin
               if (st.p_ok && st.ot_ok && st.link_slot_ok) begin
                  cmd.link_wr = 1'b1;
               end else begin
                  cmd.status_set  = 1'b1;
                  cmd.status_code = STAT_RANGE;
               end
               done_in  = 1'b1;
               state_in = ST_IDLE;
            end else if (!st.t_ok) begin
               cmd.status_set  = 1'b1;
               cmd.status_code = STAT_RANGE;
               done_in         = 1'b1;
               state_in        = ST_IDLE;
            end else begin
               case (st.func)
                  FN_SET_CORNER: begin
                     if (st.p_ok && st.corner_slot_ok) begin
                        cmd.corner_rd = 1'b1;
                        state_in      = ST_SC;
                     end else begin
                        cmd.status_set  = 1'b1;
                        cmd.status_code = STAT_RANGE;
                        done_in         = 1'b1;
                        state_in        = ST_IDLE;
                     end
                  end
                  FN_DEL_CORNER: begin
                     if (!st.corner_slot_ok) begin
                        cmd.status_set  = 1'b1;
                        cmd.status_code = STAT_RANGE;
                        done_in         = 1'b1;
                        state_in        = ST_IDLE;
                     end else if (st.ccnt_zero) begin
                        cmd.status_set  = 1'b1;
                        cmd.status_code = STAT_UNDER;
                        done_in         = 1'b1;
                        state_in        = ST_IDLE;
                     end else begin
                        cmd.ccnt_dec  = 1'b1;
                        cmd.corner_wr = 1'b1;
                        state_in      = ST_WB;
                     end
                  end
                  FN_BUILD: begin
                     cmd.clr_zero  = 1'b1;
                     cmd.walk_init = 1'b1;
                     state_in      = ST_VCLR;
                  end
                  FN_TRIM: begin
                     state_in = ST_TRIM;
                  end
                  FN_CHECK: begin
                     cmd.f_clr = 1'b1;
                     state_in  = ST_F_NEXT;
                  end
                  FN_READ: begin
                     if (st.read_ok) begin
                        cmd.ent_rd  = 1'b1;
                        cmd.ent_sel = ESEL_READ;
                        state_in    = ST_RD_WAIT;
                     end else begin
                        cmd.status_set  = 1'b1;
                        cmd.status_code = STAT_RANGE;
                        done_in         = 1'b1;
                        state_in        = ST_IDLE;
                     end
                  end
                  default: begin
                     done_in  = 1'b1;
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_SC: begin
            cmd.ccnt_inc   = st.corner_grow;
            cmd.corner_wr  = 1'b1;
            cmd.corner_set = 1'b1;
            state_in       = ST_WB;
         end
         ST_WB: begin
            cmd.cnt_wb = 1'b1;
            done_in    = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_VCLR: begin
            cmd.vis_clr = 1'b1;
            if (st.vclr_last) begin
               state_in = ST_B_CRD;
            end
         end
         ST_B_CRD: begin
            cmd.corner_rd  = 1'b1;
            cmd.corner_src = 1'b1;
            state_in       = ST_B_CCHK;
         end
         ST_B_CCHK: begin
            if (st.corner_live) begin
               cmd.vis_rd    = 1'b1;
               cmd.part_load = 1'b1;
               state_in      = ST_B_VCHK;
            end else begin
               state_in = ST_K_NEXT;
            end
         end
         ST_B_VCHK: begin
            if (st.vis_hit) begin
               state_in = ST_K_NEXT;
            end else begin
               cmd.vis_set = 1'b1;
               if (st.add_here) begin
                  cmd.l_clr = 1'b1;
                  state_in  = ST_LINK_RD;
               end else begin
                  state_in = ST_K_NEXT;
               end
            end
         end
         ST_K_NEXT: begin
            if (!st.k_last) begin
               cmd.k_inc = 1'b1;
               state_in  = ST_B_CRD;
            end else if (st.layer_one) begin
               cmd.layer_next = 1'b1;
               state_in       = ST_LAYER;
            end else begin
               cmd.j_inc = 1'b1;
               state_in  = ST_J_NEXT;
            end
         end
         ST_LAYER: begin
            if (st.layer_over) begin
               cmd.status_set  = 1'b1;
               cmd.status_code = st.full ? STAT_FULL : STAT_OK;
               state_in        = ST_WB;
            end else begin
               cmd.layer_begin = 1'b1;
               state_in        = ST_J_NEXT;
            end
         end
         ST_J_NEXT: begin
            if (st.j_end) begin
               cmd.layer_next = 1'b1;
               state_in       = ST_LAYER;
            end else begin
               cmd.ent_rd  = 1'b1;
               cmd.ent_sel = ESEL_WALK;
               state_in    = ST_J_WAIT;
            end
         end
         ST_J_WAIT: begin
            if (st.ent_ok) begin
               cmd.src_from_ent = 1'b1;
               state_in         = ST_B_CRD;
            end else begin
               cmd.j_inc = 1'b1;
               state_in  = ST_J_NEXT;
            end
         end
         ST_LINK_RD: begin
            cmd.link_rd = 1'b1;
            state_in    = ST_LINK_CHK;
         end
         ST_LINK_CHK: begin
            if (st.link_cand) begin
               cmd.f_clr = 1'b1;
               state_in  = ST_F_NEXT;
            end else begin
               state_in = ST_LINK_NEXT;
            end
         end
         ST_LINK_NEXT: begin
            if (st.l_last) begin
               state_in = ST_K_NEXT;
            end else begin
               cmd.l_inc = 1'b1;
               state_in  = ST_LINK_RD;
            end
         end
         ST_F_NEXT: begin
            if (!st.f_end) begin
               cmd.ent_rd  = 1'b1;
               cmd.ent_sel = ESEL_SCAN;
               state_in    = ST_F_WAIT;
            end else if (st.func == FN_CHECK) begin
               done_in  = 1'b1;
               state_in = ST_IDLE;
            end else if (st.list_full) begin
               cmd.full_set = 1'b1;
               state_in     = ST_LINK_NEXT;
            end else begin
               cmd.ent_wr  = 1'b1;
               cmd.cnt_inc = 1'b1;
               state_in    = ST_LINK_NEXT;
            end
         end
         ST_F_WAIT: begin
            if (!st.f_match) begin
               cmd.f_inc = 1'b1;
               state_in  = ST_F_NEXT;
            end else if (st.func == FN_CHECK) begin
               cmd.found_set = 1'b1;
               done_in       = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               state_in = ST_LINK_NEXT;
            end
         end
         ST_TRIM: begin
            if (st.cnt_zero) begin
               state_in = ST_WB;
            end else begin
               cmd.ent_rd  = 1'b1;
               cmd.ent_sel = ESEL_TRIM;
               state_in    = ST_T_WAIT;
            end
         end
         ST_T_WAIT: begin
            if (st.trim_hit) begin
               cmd.cnt_dec = 1'b1;
               state_in    = ST_TRIM;
            end else begin
               state_in = ST_WB;
            end
         end
         ST_RD_WAIT: begin
            cmd.rd_load = 1'b1;
            done_in     = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         busy_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= state_in != ST_IDLE;
         rsp_valid_ff <= done_in;
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/core/tetra_layered_neighbor_table_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Layered tetrahedron neighbor table
// Keeps tetra corners, particle links and per-tetra neighbor lists, and
// runs one table operation per request word.
// ----------------------------------------------------------------------------
// A request word is taken at a clock edge where start is high and busy is
// low. Each request yields one response word on rsp_word, shown for exactly
// one cycle with rsp_valid; the receiver cannot hold it off. busy stays high
// from acceptance until the strobe cycle, in which a new word may already be
// taken.
// Check compares list entries in order until the tetra is found or the list
// ends. Trim removes entries from the end of the list while their layer is at
// or above the start layer. Build clears the visited bitmap, then reads each
// corner slot, examines the links of newly visited corner particles, compares
// each new candidate against the list entries, and walks the listed entries of
// each later layer.
// The table memories each have one write port and one registered read port
// and are stepped through one access at a time by the sequencer.
// After reset the block runs a clearing pass with busy high.
// ----------------------------------------------------------------------------
module tetra_layered_neighbor_table_core #(
   parameter int PARTICLES          = 1024,
   parameter int TETRAS             = 1024,
   parameter int LINKS_PER_PARTICLE = 16,
   parameter int NEIGHBOR_MAX       = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  tlnt_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   output tlnt_pkg::rsp_word_type rsp_word
);
   import tlnt_pkg::*;

   cmd_type  cmd;
   stat_type st;

   tlnt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .st        (st),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   tlnt_dpath #(
      .PARTICLES          (PARTICLES),
      .TETRAS             (TETRAS),
      .LINKS_PER_PARTICLE (LINKS_PER_PARTICLE),
      .NEIGHBOR_MAX       (NEIGHBOR_MAX)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_word (req_word),
      .cmd      (cmd),
      .st       (st),
      .rsp_word (rsp_word)
   );

endmodule

@@ verif/tetra_layered_neighbor_table_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Neighbor table response checker
// Watches the request and response channels, keeps its own copy of the
// corner, link and neighbor tables, and predicts every response word.
// Each response is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tetra_layered_neighbor_table_checker
   import tlnt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic         busy,
   input  req_word_type req_word,
   input  logic         rsp_valid,
   input  rsp_word_type rsp_word,
   output int           failures,
   output int           pending
);

   localparam int PARTS = 1024;
   localparam int TETS  = 1024;
   localparam int LINKS = 16;
   localparam int NMAX  = 64;

   corner_type corner_tab [TETS*CORNERS];
   int         corner_cnt [TETS];
   link_type   link_tab   [PARTS*LINKS];
   entry_type  nbr_tab    [TETS*NMAX];
   int         nbr_cnt    [TETS];
   bit         seen       [PARTS];

   rsp_word_type expected_rsp [$];

   function automatic int find_nbr(int t, int target);
      for (int k = 0; k < nbr_cnt[t]; k++)
         if (int'(nbr_tab[t*NMAX+k].tetra) == target) return k;
      return -1;
   endfunction

   task automatic append_links(int t, int p, int layer, inout bit full);
      link_type lk;
      for (int l = 0; l < LINKS; l++) begin
         lk = link_tab[p*LINKS+l];
         if (!lk.valid || int'(lk.tetra) == t) continue;
         if (find_nbr(t, int'(lk.tetra)) >= 0) continue;
         if (nbr_cnt[t] >= NMAX) begin
            full = 1;
            continue;
         end
         nbr_tab[t*NMAX+nbr_cnt[t]].tetra = lk.tetra;
         nbr_tab[t*NMAX+nbr_cnt[t]].layer = layer[3:0];
         nbr_cnt[t]++;
      end
   endtask

   task automatic walk_layers(int t, int search, int first, output bit full);
      int lo, hi, eff, jt;
      corner_type c;
      full = 0;
      lo = 0;
      foreach (seen[i]) seen[i] = 0;
      for (int k = 0; k < CORNERS; k++) begin
         c = corner_tab[t*CORNERS+k];
         if (!c.valid || seen[c.particle]) continue;
         seen[c.particle] = 1;
         if (first == 1) append_links(t, int'(c.particle), 1, full);
      end
      eff = (first == 1) ? 2 : first;
      for (int i = 2; i <= search; i++) begin
         hi = nbr_cnt[t];
         for (int j = lo; j < hi; j++) begin
            jt = int'(nbr_tab[t*NMAX+j].tetra);
            for (int k = 0; k < CORNERS; k++) begin
               c = corner_tab[jt*CORNERS+k];
               if (!c.valid || seen[c.particle]) continue;
               seen[c.particle] = 1;
               if (i < eff) continue;
               append_links(t, int'(c.particle), i, full);
            end
         end
         lo = hi;
      end
   endtask

   task automatic predict(input req_word_type w, output rsp_word_type r);
      int t, p, s, idx;
      bit full;
      t = int'(w.tetra);
      p = int'(w.particle);
      s = int'(w.slot);
      r = '0;
      case (func_type'(w.func))
         FN_SET_LINK: begin
            if (s >= LINKS) r.status = STAT_RANGE;
            else link_tab[p*LINKS+s] = '{valid: 1'b1, order: w.order, tetra: w.other_tetra};
         end
         FN_SET_CORNER: begin
            if (s >= CORNERS) r.status = STAT_RANGE;
            else begin
               if (!corner_tab[t*CORNERS+s].valid && corner_cnt[t] < CORNERS)
                  corner_cnt[t]++;
               corner_tab[t*CORNERS+s] = '{valid: 1'b1, particle: w.particle};
            end
         end
         FN_DEL_CORNER: begin
            if (s >= CORNERS) r.status = STAT_RANGE;
            else if (corner_cnt[t] == 0) r.status = STAT_UNDER;
            else begin
               corner_cnt[t]--;
               corner_tab[t*CORNERS+s] = '0;
            end
         end
         FN_BUILD: begin
            walk_layers(t, int'(w.search_layer), int'(w.start_layer), full);
            if (full) r.status = STAT_FULL;
         end
         FN_TRIM: begin
            while (nbr_cnt[t] > 0 && nbr_tab[t*NMAX+nbr_cnt[t]-1].layer >= w.start_layer)
               nbr_cnt[t]--;
         end
         FN_CHECK: begin
            idx = find_nbr(t, int'(w.other_tetra));
            if (idx >= 0) begin
               r.found = 1'b1;
               r.found_index = idx[5:0];
            end
         end
         FN_READ: begin
            if (s >= nbr_cnt[t]) r.status = STAT_RANGE;
            else begin
               r.neighbor_tetra = nbr_tab[t*NMAX+s].tetra;
               r.neighbor_layer = nbr_tab[t*NMAX+s].layer;
            end
         end
         default: ;
      endcase
      r.count_now = nbr_cnt[t][6:0];
   endtask

   initial begin
      failures = 0;
      foreach (corner_tab[i]) corner_tab[i] = '0;
      foreach (corner_cnt[i]) corner_cnt[i] = 0;
      foreach (link_tab[i]) link_tab[i] = '0;
      foreach (nbr_tab[i]) nbr_tab[i] = '0;
      foreach (nbr_cnt[i]) nbr_cnt[i] = 0;
   end

   assign pending = expected_rsp.size();

   always @(posedge clock) begin
      rsp_word_type want;
      rsp_word_type got;
      if (!reset && rsp_valid) begin
         got = rsp_word;
         if (expected_rsp.size() == 0) begin
            $error("response word with no request outstanding");
            failures++;
         end else begin
            want = expected_rsp.pop_front();
            if (got.status !== want.status) begin
               $error("status expected %0d actual %0d", want.status, got.status);
               failures++;
            end
            if (got.found !== want.found) begin
               $error("found expected %0d actual %0d", want.found, got.found);
               failures++;
            end
            if (got.found_index !== want.found_index) begin
               $error("found_index expected %0d actual %0d", want.found_index,
                      got.found_index);
               failures++;
            end
            if (got.neighbor_tetra !== want.neighbor_tetra) begin
               $error("neighbor_tetra expected %0d actual %0d", want.neighbor_tetra,
                      got.neighbor_tetra);
               failures++;
            end
            if (got.neighbor_layer !== want.neighbor_layer) begin
               $error("neighbor_layer expected %0d actual %0d", want.neighbor_layer,
                      got.neighbor_layer);
               failures++;
            end
            if (got.count_now !== want.count_now) begin
               $error("count_now expected %0d actual %0d", want.count_now, got.count_now);
               failures++;
            end
         end
      end
      // A word may be taken in the same cycle as a strobe; it is predicted after.
      if (!reset && start && !busy) begin
         predict(req_word, want);
         expected_rsp.insert(expected_rsp.size(), want);
      end
   end

endmodule

@@ verif/tetra_layered_neighbor_table_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Neighbor table core testbench
// Drives directed and random operation words into the core with random
// gaps, over a small particle and tetra pool so that builds find deep and
// full lists. The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tetra_layered_neighbor_table_core_tb;
   import tlnt_pkg::*;

   localparam int RW = $bits(req_word_type);

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   req_word_type req_word = '0;
   logic         rsp_valid;
   rsp_word_type rsp_word;
   int           failures;
   int           pending;

   always #5 clock = ~clock;

   tetra_layered_neighbor_table_core u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word)
   );

   tetra_layered_neighbor_table_checker u_checker (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .failures  (failures),
      .pending   (pending)
   );

   // Hold the word until it is taken; busy only moves at rising edges.
   task automatic send_word(input req_word_type w, input int gap);
      @(negedge clock);
      start    <= 1'b1;
      req_word <= w;
      while (busy) @(negedge clock);
      @(posedge clock);
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   function automatic req_word_type make_word(func_type f, int t, int p, int s,
                                              int ot, int sl, int st);
      req_word_type w;
      w = '0;
      w.func = f;
      w.tetra = 10'(t);
      w.particle = 10'(p);
      w.slot = 6'(s);
      w.other_tetra = 10'(ot);
      w.order = 2'($urandom_range(0, 3));
      w.search_layer = 4'(sl);
      w.start_layer = 4'(st);
      return w;
   endfunction

   function automatic req_word_type random_word();
      req_word_type w;
      int pick;
      pick = $urandom_range(0, 99);
      w = make_word(FN_NOP, $urandom_range(0, 23), $urandom_range(0, 31),
                    $urandom_range(0, 3), $urandom_range(0, 95),
                    $urandom_range(1, 4), $urandom_range(1, 3));
      if (pick < 30) begin
         w.func = FN_SET_LINK;
         w.slot = 6'($urandom_range(0, 15));
      end else if (pick < 50) w.func = FN_SET_CORNER;
      else if (pick < 58) w.func = FN_DEL_CORNER;
      else if (pick < 66) w.func = FN_BUILD;
      else if (pick < 74) w.func = FN_TRIM;
      else if (pick < 84) w.func = FN_CHECK;
      else begin
         w.func = FN_READ;
         w.slot = 6'($urandom_range(0, 40));
      end
      // Noise: every field random over its full range, except a build's search layer.
      if ($urandom_range(0, 9) == 0) begin
         w = req_word_type'(RW'({$urandom(), $urandom()}));
         w.func = 3'($urandom_range(0, 7));
         if (w.func == FN_BUILD) w.search_layer = 4'($urandom_range(0, 3));
      end
      return w;
   endfunction

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Small mesh: tetras 0, 1 and 1023 get corners, links reach further tetras.
      send_word(make_word(FN_DEL_CORNER, 0, 0, 0, 0, 1, 1), 0);
      send_word(make_word(FN_SET_CORNER, 0, 1, 0, 0, 1, 1), 0);
      send_word(make_word(FN_SET_CORNER, 0, 2, 3, 0, 1, 1), 0);
      send_word(make_word(FN_SET_CORNER, 0, 2, 3, 0, 1, 1), 2);
      send_word(make_word(FN_SET_CORNER, 0, 1, 4, 0, 1, 1), 0);
      send_word(make_word(FN_SET_CORNER, 1, 3, 0, 0, 1, 1), 0);
      send_word(make_word(FN_SET_CORNER, 1023, 1023, 1, 0, 1, 1), 0);
      send_word(make_word(FN_SET_LINK, 0, 1, 0, 1, 1, 1), 0);
      send_word(make_word(FN_SET_LINK, 0, 1, 15, 0, 1, 1), 0);
      send_word(make_word(FN_SET_LINK, 0, 2, 1, 1023, 1, 1), 0);
      send_word(make_word(FN_SET_LINK, 0, 3, 0, 2, 1, 1), 0);
      send_word(make_word(FN_SET_LINK, 0, 1023, 16, 5, 1, 1), 0);
      send_word(make_word(FN_BUILD, 0, 0, 0, 0, 3, 1), 3);
      send_word(make_word(FN_CHECK, 0, 0, 0, 1023, 1, 1), 0);
      send_word(make_word(FN_CHECK, 0, 0, 0, 7, 1, 1), 0);
      send_word(make_word(FN_READ, 0, 0, 1, 0, 1, 1), 0);
      send_word(make_word(FN_READ, 0, 0, 63, 0, 1, 1), 0);
      send_word(make_word(FN_TRIM, 0, 0, 0, 0, 1, 2), 0);
      send_word(make_word(FN_BUILD, 1, 0, 0, 0, 0, 0), 0);
      send_word(make_word(FN_BUILD, 1, 0, 0, 0, 15, 15), 0);
      send_word(make_word(FN_TRIM, 0, 0, 0, 0, 1, 0), 0);
      send_word(make_word(FN_DEL_CORNER, 0, 0, 3, 0, 1, 1), 0);
      send_word(make_word(FN_DEL_CORNER, 0, 0, 3, 0, 1, 1), 0);
      send_word(make_word(FN_NOP, 1023, 1023, 63, 1023, 15, 15), 0);

      for (int n = 0; n < 300; n++) begin
         if (n == 150) begin
            @(negedge clock);
            start <= 1'b0;
            while (pending != 0) @(negedge clock);
         end
         send_word(random_word(), ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 19));
      end

      @(negedge clock);
      start <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (failures == 0) $display("tetra_layered_neighbor_table_core verification clean");
      else $display("tetra_layered_neighbor_table_core verification failed");
      $finish;
   end

   initial begin
      #400_000_000;
      $display("tetra_layered_neighbor_table_core verification failed");
      $finish;
   end

endmodule
